@@ design/mcma_pkg.sv @@
// shared constants for the manhattan assignment solver
`timescale 1ns / 1ps

package mcma_pkg;

    localparam int MAX_PAIRS_DEF   = 64;
    localparam int COORD_WIDTH_DEF = 7;

    localparam int OP_W    = 2;
    localparam int FIELD_W = 7;
    localparam int COST_W  = 14;

    localparam logic [OP_W-1:0] OP_HOUSE  = 2'd0;
    localparam logic [OP_W-1:0] OP_WORKER = 2'd1;
    localparam logic [OP_W-1:0] OP_SOLVE  = 2'd2;

    localparam logic [COST_W-1:0] COST_SAT = 14'h3fff;

    // potentials and slack values, signed
    localparam int POT_W = 24;
    localparam logic signed [POT_W-1:0] POT_INF = 24'sh400000;

    localparam logic ALU_ADD = 1'b0;
    localparam logic ALU_SUB = 1'b1;

endpackage

@@ design/mcma_alu.sv @@
// shared add / subtract unit for potential arithmetic
`timescale 1ns / 1ps

module mcma_alu
(
    input  logic                                 op,
    input  logic signed [mcma_pkg::POT_W-1:0]    a,
    input  logic signed [mcma_pkg::POT_W-1:0]    b,
    output logic signed [mcma_pkg::POT_W-1:0]    y
);

    always_comb
    begin
        if (op == mcma_pkg::ALU_SUB)
        begin
            y = a - b;
        end
        else
        begin
            y = a + b;
        end
    end

endmodule

@@ design/mcma_solver.sv @@
// point stores and hungarian-method sequencer around one shared adder
`timescale 1ns / 1ps

module mcma_solver
#(
    parameter int MAX_PAIRS   = mcma_pkg::MAX_PAIRS_DEF,
    parameter int COORD_WIDTH = mcma_pkg::COORD_WIDTH_DEF,
    parameter int IW          = $clog2(MAX_PAIRS + 1)
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          ld_en,
    input  logic                          ld_worker,
    input  logic [IW-1:0]                 ld_addr,
    input  logic [COORD_WIDTH-1:0]        ld_row,
    input  logic [COORD_WIDTH-1:0]        ld_col,
    input  logic                          start,
    input  logic [IW-1:0]                 n_pairs,
    output logic                          done,
    output logic [mcma_pkg::COST_W-1:0]   total
);

    localparam int DEPTH = MAX_PAIRS + 1;
    localparam int CW    = $clog2(MAX_PAIRS + 2);
    localparam int PTW   = 2 * COORD_WIDTH;
    localparam int XW    = COORD_WIDTH + 1;
    localparam int PW    = mcma_pkg::POT_W;

    typedef enum logic [4:0] {
        S_IDLE, S_INIT, S_ROW, S_STEP, S_STEP_W, S_STEP_R,
        S_SCAN_A, S_SCAN_B, S_SCAN_C, S_UPD_COL, S_UPD_COL_B,
        S_UPD_ROW, S_UPD_ROW_B, S_CHK, S_AUG, S_AUG_B, S_AUG_C,
        S_FIN, S_FIN_B
    } state_t;

    // storage, entry 0 of the point stores is unused (points are 1-based)
    logic [PTW-1:0]         hp_mem   [DEPTH];
    logic [PTW-1:0]         wp_mem   [DEPTH];
    logic signed [PW-1:0]   u_mem    [DEPTH];
    logic signed [PW-1:0]   v_mem    [DEPTH];
    logic [IW-1:0]          p_mem    [DEPTH];
    logic [IW-1:0]          way_mem  [DEPTH];
    logic signed [PW-1:0]   minv_mem [DEPTH];

    logic [PTW-1:0]         hp_rd, wp_rd;
    logic signed [PW-1:0]   u_rd, v_rd, minv_rd;
    logic [IW-1:0]          p_rd, way_rd;

    logic [IW-1:0]          hp_ra, wp_ra, row_ra, col_ra, col_wa, u_wa;
    logic                   u_we, v_we, p_we, way_we, minv_we;
    logic signed [PW-1:0]   u_wd, v_wd, minv_wd;
    logic [IW-1:0]          p_wd, way_wd;

    state_t                 state_reg, state_next;
    logic [CW-1:0]          i_reg, i_next, j_reg, j_next;
    logic [IW-1:0]          j0_reg, j0_next, j1_reg, j1_next, n_reg, n_next;
    logic signed [PW-1:0]   ui0_reg, ui0_next, uv_reg, uv_next, delta_reg, delta_next;
    logic [PTW-1:0]         hp_reg, hp_next;
    logic [XW-1:0]          cost_reg, cost_next;
    logic [DEPTH-1:0]       used_reg, used_next, rused_reg, rused_next;
    logic [DEPTH-1:0]       mvalid_reg, mvalid_next;
    logic                   done_reg, done_next;
    logic [mcma_pkg::COST_W-1:0] total_reg, total_next;

    logic                   alu_op;
    logic signed [PW-1:0]   alu_a, alu_b, alu_y;
    logic [IW-1:0]          jj;
    logic [COORD_WIDTH-1:0] dr, dc;
    logic [XW-1:0]          man_dist;
    logic signed [PW-1:0]   mold, mnew;

    mcma_alu u_alu
    (
        .op (alu_op),
        .a  (alu_a),
        .b  (alu_b),
        .y  (alu_y)
    );

    assign jj = j_reg[IW-1:0];

    // manhattan distance of the held house point to the worker just read
    always_comb
    begin
        if (hp_reg[PTW-1:COORD_WIDTH] > wp_rd[PTW-1:COORD_WIDTH])
        begin
            dr = hp_reg[PTW-1:COORD_WIDTH] - wp_rd[PTW-1:COORD_WIDTH];
        end
        else
        begin
            dr = wp_rd[PTW-1:COORD_WIDTH] - hp_reg[PTW-1:COORD_WIDTH];
        end
        if (hp_reg[COORD_WIDTH-1:0] > wp_rd[COORD_WIDTH-1:0])
        begin
            dc = hp_reg[COORD_WIDTH-1:0] - wp_rd[COORD_WIDTH-1:0];
        end
        else
        begin
            dc = wp_rd[COORD_WIDTH-1:0] - hp_reg[COORD_WIDTH-1:0];
        end
        man_dist = XW'(dr) + XW'(dc);
    end

    always_ff @(posedge clk)
    begin
        if (ld_en && !ld_worker)
        begin
            hp_mem[ld_addr] <= {ld_row, ld_col};
        end
        if (ld_en && ld_worker)
        begin
            wp_mem[ld_addr] <= {ld_row, ld_col};
        end
        if (u_we)
        begin
            u_mem[u_wa] <= u_wd;
        end
        if (v_we)
        begin
            v_mem[col_wa] <= v_wd;
        end
        if (p_we)
        begin
            p_mem[col_wa] <= p_wd;
        end
        if (way_we)
        begin
            way_mem[col_wa] <= way_wd;
        end
        if (minv_we)
        begin
            minv_mem[col_wa] <= minv_wd;
        end
        hp_rd   <= hp_mem[hp_ra];
        wp_rd   <= wp_mem[wp_ra];
        u_rd    <= u_mem[row_ra];
        v_rd    <= v_mem[col_ra];
        p_rd    <= p_mem[col_ra];
        way_rd  <= way_mem[col_ra];
        minv_rd <= minv_mem[col_ra];
    end

    always_comb
    begin
        state_next  = state_reg;
        i_next      = i_reg;
        j_next      = j_reg;
        j0_next     = j0_reg;
        j1_next     = j1_reg;
        n_next      = n_reg;
        ui0_next    = ui0_reg;
        uv_next     = uv_reg;
        delta_next  = delta_reg;
        hp_next     = hp_reg;
        cost_next   = cost_reg;
        used_next   = used_reg;
        rused_next  = rused_reg;
        mvalid_next = mvalid_reg;
        done_next   = 1'b0;
        total_next  = total_reg;

        hp_ra   = '0;
        wp_ra   = '0;
        row_ra  = '0;
        col_ra  = '0;
        col_wa  = '0;
        u_wa    = '0;
        u_we    = 1'b0;
        v_we    = 1'b0;
        p_we    = 1'b0;
        way_we  = 1'b0;
        minv_we = 1'b0;
        u_wd    = '0;
        v_wd    = '0;
        p_wd    = '0;
        way_wd  = j0_reg;
        minv_wd = alu_y;
        alu_op  = mcma_pkg::ALU_ADD;
        alu_a   = '0;
        alu_b   = '0;
        mold    = mcma_pkg::POT_INF;
        mnew    = mcma_pkg::POT_INF;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    n_next     = n_pairs;
                    j_next     = '0;
                    state_next = S_INIT;
                end
            end

            S_INIT:
            begin
                col_wa = jj;
                u_wa   = jj;
                v_we   = 1'b1;
                p_we   = 1'b1;
                u_we   = 1'b1;
                if (j_reg == CW'(n_reg))
                begin
                    i_next     = CW'(1);
                    state_next = S_ROW;
                end
                else
                begin
                    j_next = j_reg + CW'(1);
                end
            end

            S_ROW:
            begin
                col_wa      = '0;
                p_we        = 1'b1;
                p_wd        = i_reg[IW-1:0];
                j0_next     = '0;
                used_next   = '0;
                rused_next  = '0;
                mvalid_next = '0;
                state_next  = S_STEP;
            end

            S_STEP:
            begin
                used_next[j0_reg] = 1'b1;
                col_ra            = j0_reg;
                state_next        = S_STEP_W;
            end

            S_STEP_W:
            begin
                rused_next[p_rd] = 1'b1;
                row_ra           = p_rd;
                hp_ra            = p_rd;
                state_next       = S_STEP_R;
            end

            S_STEP_R:
            begin
                ui0_next   = u_rd;
                hp_next    = hp_rd;
                delta_next = mcma_pkg::POT_INF;
                j_next     = CW'(1);
                state_next = S_SCAN_A;
            end

            S_SCAN_A:
            begin
                if (j_reg > CW'(n_reg))
                begin
                    j_next     = '0;
                    state_next = S_UPD_COL;
                end
                else if (used_reg[jj])
                begin
                    j_next = j_reg + CW'(1);
                end
                else
                begin
                    col_ra     = jj;
                    wp_ra      = jj;
                    state_next = S_SCAN_B;
                end
            end

            S_SCAN_B:
            begin
                // keep the column address so minv stays readable next cycle
                col_ra     = jj;
                cost_next  = man_dist;
                alu_op     = mcma_pkg::ALU_ADD;
                alu_a      = ui0_reg;
                alu_b      = v_rd;
                uv_next    = alu_y;
                state_next = S_SCAN_C;
            end

            S_SCAN_C:
            begin
                // slack of this column against the current row
                alu_op = mcma_pkg::ALU_SUB;
                alu_a  = $signed(PW'(cost_reg));
                alu_b  = uv_reg;
                col_wa = jj;
                mold   = mvalid_reg[jj] ? minv_rd : mcma_pkg::POT_INF;
                if (alu_y < mold)
                begin
                    minv_we         = 1'b1;
                    way_we          = 1'b1;
                    mvalid_next[jj] = 1'b1;
                    mnew            = alu_y;
                end
                else
                begin
                    mnew = mold;
                end
                if (mnew < delta_reg)
                begin
                    delta_next = mnew;
                    j1_next    = jj;
                end
                j_next     = j_reg + CW'(1);
                state_next = S_SCAN_A;
            end

            S_UPD_COL:
            begin
                if (j_reg > CW'(n_reg))
                begin
                    j_next     = CW'(1);
                    state_next = S_UPD_ROW;
                end
                else
                begin
                    col_ra     = jj;
                    state_next = S_UPD_COL_B;
                end
            end

            S_UPD_COL_B:
            begin
                col_wa = jj;
                alu_op = mcma_pkg::ALU_SUB;
                alu_b  = delta_reg;
                if (used_reg[jj])
                begin
                    alu_a = v_rd;
                    v_wd  = alu_y;
                    v_we  = 1'b1;
                end
                else if (mvalid_reg[jj])
                begin
                    alu_a   = minv_rd;
                    minv_we = 1'b1;
                end
                j_next     = j_reg + CW'(1);
                state_next = S_UPD_COL;
            end

            S_UPD_ROW:
            begin
                if (j_reg > CW'(n_reg))
                begin
                    j0_next    = j1_reg;
                    col_ra     = j1_reg;
                    state_next = S_CHK;
                end
                else if (rused_reg[jj])
                begin
                    row_ra     = jj;
                    state_next = S_UPD_ROW_B;
                end
                else
                begin
                    j_next = j_reg + CW'(1);
                end
            end

            S_UPD_ROW_B:
            begin
                alu_op     = mcma_pkg::ALU_ADD;
                alu_a      = u_rd;
                alu_b      = delta_reg;
                u_wa       = jj;
                u_wd       = alu_y;
                u_we       = 1'b1;
                j_next     = j_reg + CW'(1);
                state_next = S_UPD_ROW;
            end

            S_CHK:
            begin
                // column still owned by a row: keep growing the tree
                if (p_rd != '0)
                begin
                    state_next = S_STEP;
                end
                else
                begin
                    state_next = S_AUG;
                end
            end

            S_AUG:
            begin
                col_ra     = j0_reg;
                state_next = S_AUG_B;
            end

            S_AUG_B:
            begin
                col_ra     = way_rd;
                j1_next    = way_rd;
                state_next = S_AUG_C;
            end

            S_AUG_C:
            begin
                col_wa  = j0_reg;
                p_we    = 1'b1;
                p_wd    = p_rd;
                j0_next = j1_reg;
                if (j1_reg == '0)
                begin
                    if (i_reg == CW'(n_reg))
                    begin
                        state_next = S_FIN;
                    end
                    else
                    begin
                        i_next     = i_reg + CW'(1);
                        state_next = S_ROW;
                    end
                end
                else
                begin
                    state_next = S_AUG;
                end
            end

            S_FIN:
            begin
                col_ra     = '0;
                state_next = S_FIN_B;
            end

            S_FIN_B:
            begin
                alu_op = mcma_pkg::ALU_SUB;
                alu_a  = '0;
                alu_b  = v_rd;
                if (alu_y > $signed(PW'(mcma_pkg::COST_SAT)))
                begin
                    total_next = mcma_pkg::COST_SAT;
                end
                else
                begin
                    total_next = alu_y[mcma_pkg::COST_W-1:0];
                end
                done_next  = 1'b1;
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            done_reg   <= 1'b0;
            used_reg   <= '0;
            rused_reg  <= '0;
            mvalid_reg <= '0;
            i_reg      <= '0;
            j_reg      <= '0;
            j0_reg     <= '0;
            j1_reg     <= '0;
            n_reg      <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            done_reg   <= done_next;
            used_reg   <= used_next;
            rused_reg  <= rused_next;
            mvalid_reg <= mvalid_next;
            i_reg      <= i_next;
            j_reg      <= j_next;
            j0_reg     <= j0_next;
            j1_reg     <= j1_next;
            n_reg      <= n_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ui0_reg   <= ui0_next;
        uv_reg    <= uv_next;
        delta_reg <= delta_next;
        hp_reg    <= hp_next;
        cost_reg  <= cost_next;
        total_reg <= total_next;
    end

    assign done  = done_reg;
    assign total = total_reg;

endmodule

@@ design/min_cost_manhattan_assignment_top.sv @@
// min-cost manhattan assignment: point loading, request handling, result register
// load requests are taken while no solve is running; a solve request of n pairs with
// equal counts first clears potentials and matches 0 to n, then for row i runs up to
// i tree steps, all through one shared adder and single-read memories; unequal counts
// or empty stores answer the next cycle; a solve stalls while a result waits
// reset clears counts, overflow flag, sequencer and output valid; point stores are not cleared
`timescale 1ns / 1ps

module min_cost_manhattan_assignment_top
#(
    parameter int MAX_PAIRS   = mcma_pkg::MAX_PAIRS_DEF,
    parameter int COORD_WIDTH = mcma_pkg::COORD_WIDTH_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [mcma_pkg::OP_W-1:0]      op,
    input  logic [mcma_pkg::FIELD_W-1:0]   row,
    input  logic [mcma_pkg::FIELD_W-1:0]   col,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [mcma_pkg::COST_W-1:0]    total_cost,
    output logic                           count_mismatch,
    output logic                           overflowed
);

    localparam int IW = $clog2(MAX_PAIRS + 1);

    logic [IW-1:0]               hcnt_reg, hcnt_next, wcnt_reg, wcnt_next;
    logic                        ovf_reg, ovf_next, wait_reg, wait_next;
    logic                        ov_reg, ov_next, mism_reg, mism_next, oflag_reg, oflag_next;
    logic [mcma_pkg::COST_W-1:0] tot_reg, tot_next;
    logic                        accept, ld_en, ld_worker, start, done;
    logic [IW-1:0]               ld_addr;
    logic [mcma_pkg::COST_W-1:0] sol_total;

    assign in_stall = wait_reg || (op == mcma_pkg::OP_SOLVE && ov_reg);
    assign accept   = in_valid && !in_stall;

    mcma_solver
    #(
        .MAX_PAIRS   (MAX_PAIRS),
        .COORD_WIDTH (COORD_WIDTH),
        .IW          (IW)
    )
    u_solver
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .ld_en     (ld_en),
        .ld_worker (ld_worker),
        .ld_addr   (ld_addr),
        .ld_row    (COORD_WIDTH'(row)),
        .ld_col    (COORD_WIDTH'(col)),
        .start     (start),
        .n_pairs   (hcnt_reg),
        .done      (done),
        .total     (sol_total)
    );

    always_comb
    begin
        hcnt_next  = hcnt_reg;
        wcnt_next  = wcnt_reg;
        ovf_next   = ovf_reg;
        wait_next  = wait_reg;
        ov_next    = ov_reg;
        mism_next  = mism_reg;
        oflag_next = oflag_reg;
        tot_next   = tot_reg;
        ld_en      = 1'b0;
        ld_worker  = (op == mcma_pkg::OP_WORKER);
        ld_addr    = '0;
        start      = 1'b0;

        if (ov_reg && !out_stall)
        begin
            ov_next = 1'b0;
        end

        if (done)
        begin
            tot_next  = sol_total;
            ov_next   = 1'b1;
            wait_next = 1'b0;
        end

        if (accept)
        begin
            case (op)
                mcma_pkg::OP_HOUSE:
                begin
                    if (hcnt_reg == IW'(MAX_PAIRS))
                    begin
                        ovf_next = 1'b1;
                    end
                    else
                    begin
                        ld_en     = 1'b1;
                        ld_addr   = hcnt_reg + IW'(1);
                        hcnt_next = hcnt_reg + IW'(1);
                    end
                end

                mcma_pkg::OP_WORKER:
                begin
                    if (wcnt_reg == IW'(MAX_PAIRS))
                    begin
                        ovf_next = 1'b1;
                    end
                    else
                    begin
                        ld_en     = 1'b1;
                        ld_addr   = wcnt_reg + IW'(1);
                        wcnt_next = wcnt_reg + IW'(1);
                    end
                end

                mcma_pkg::OP_SOLVE:
                begin
                    mism_next  = (hcnt_reg != wcnt_reg);
                    oflag_next = ovf_reg;
                    tot_next   = '0;
                    // nothing to search: answer right away
                    if (hcnt_reg != wcnt_reg || hcnt_reg == '0)
                    begin
                        ov_next = 1'b1;
                    end
                    else
                    begin
                        start     = 1'b1;
                        wait_next = 1'b1;
                    end
                    hcnt_next = '0;
                    wcnt_next = '0;
                    ovf_next  = 1'b0;
                end

                default:
                begin
                    ld_en = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hcnt_reg <= '0;
            wcnt_reg <= '0;
            ovf_reg  <= 1'b0;
            wait_reg <= 1'b0;
            ov_reg   <= 1'b0;
        end
        else
        begin
            hcnt_reg <= hcnt_next;
            wcnt_reg <= wcnt_next;
            ovf_reg  <= ovf_next;
            wait_reg <= wait_next;
            ov_reg   <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mism_reg  <= mism_next;
        oflag_reg <= oflag_next;
        tot_reg   <= tot_next;
    end

    assign out_valid      = ov_reg;
    assign total_cost     = tot_reg;
    assign count_mismatch = mism_reg;
    assign overflowed     = oflag_reg;

endmodule

@@ tb/min_cost_manhattan_assignment_top_tb.sv @@
// testbench for the min-cost manhattan assignment solver
`timescale 1ns / 1ps

module min_cost_manhattan_assignment_top_tb;

    localparam int NPAIRS     = mcma_pkg::MAX_PAIRS_DEF;
    localparam int CYCLE_CAP  = 4000000;
    localparam int ITEM_GOAL  = 1350;
    localparam int OPW        = mcma_pkg::OP_W;
    localparam int FW         = mcma_pkg::FIELD_W;
    localparam int CSW        = mcma_pkg::COST_W;
    localparam logic [OPW-1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [CSW-1:0] cost;
        logic           mismatch;
        logic           ovf;
    } solve_result_t;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    logic [OPW-1:0]       op;
    logic [FW-1:0]        row;
    logic [FW-1:0]        col;
    logic                 out_valid;
    logic                 out_stall;
    logic [CSW-1:0]       total_cost;
    logic                 count_mismatch;
    logic                 overflowed;

    min_cost_manhattan_assignment_top uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .op(op), .row(row), .col(col),
        .out_valid(out_valid), .out_stall(out_stall),
        .total_cost(total_cost), .count_mismatch(count_mismatch),
        .overflowed(overflowed)
    );

    // predictor copy of the point stores
    logic [FW-1:0]      house_r [NPAIRS];
    logic [FW-1:0]      house_c [NPAIRS];
    logic [FW-1:0]      worker_r [NPAIRS];
    logic [FW-1:0]      worker_c [NPAIRS];
    int unsigned        houses_held;
    int unsigned        workers_held;
    bit                 dropped_seen;

    solve_result_t      pending_totals[$];
    int unsigned        errors;
    int unsigned        requests_sent;
    int unsigned        solves_checked;
    int unsigned        cycles;
    int unsigned        hold_off;

    initial clk = 1'b0;
    always #6 clk = ~clk;

    function automatic int pair_cost(int h, int w);
        int dr;
        int dc;
        dr = int'(house_r[h]) - int'(worker_r[w]);
        dc = int'(house_c[h]) - int'(worker_c[w]);
        if (dr < 0) dr = -dr;
        if (dc < 0) dc = -dc;
        return dr + dc;
    endfunction

    // optimal assignment total by the potential method, same optimum as augmenting paths
    function automatic int best_total(int n);
        int  u [0:NPAIRS];
        int  v [0:NPAIRS];
        int  p [0:NPAIRS];
        int  way [0:NPAIRS];
        int  minv [0:NPAIRS];
        bit  used [0:NPAIRS];
        int  i, j, j0, j1, i0, delta, c, total;
        for (j = 0; j <= NPAIRS; j++)
        begin
            u[j] = 0; v[j] = 0; p[j] = 0; way[j] = 0;
        end
        for (i = 1; i <= n; i++)
        begin
            p[0] = i;
            j0 = 0;
            for (j = 0; j <= n; j++)
            begin
                minv[j] = 32'h3fffffff;
                used[j] = 1'b0;
            end
            do
            begin
                used[j0] = 1'b1;
                i0 = p[j0];
                delta = 32'h3fffffff;
                j1 = 0;
                for (j = 1; j <= n; j++)
                begin
                    if (!used[j])
                    begin
                        c = pair_cost(i0 - 1, j - 1) - u[i0] - v[j];
                        if (c < minv[j])
                        begin
                            minv[j] = c;
                            way[j] = j0;
                        end
                        if (minv[j] < delta)
                        begin
                            delta = minv[j];
                            j1 = j;
                        end
                    end
                end
                for (j = 0; j <= n; j++)
                begin
                    if (used[j])
                    begin
                        u[p[j]] += delta;
                        v[j] -= delta;
                    end
                    else
                        minv[j] -= delta;
                end
                j0 = j1;
            end while (p[j0] != 0);
            do
            begin
                j1 = way[j0];
                p[j0] = p[j1];
                j0 = j1;
            end while (j0 != 0);
        end
        total = 0;
        for (j = 1; j <= n; j++)
            total += pair_cost(p[j] - 1, j - 1);
        return total;
    endfunction

    task automatic predict_request(logic [OPW-1:0] o, logic [FW-1:0] r,
                                   logic [FW-1:0] c);
        solve_result_t res;
        int t;
        if (o == mcma_pkg::OP_HOUSE)
        begin
            if (houses_held >= NPAIRS) dropped_seen = 1'b1;
            else
            begin
                house_r[houses_held] = r;
                house_c[houses_held] = c;
                houses_held++;
            end
        end
        else if (o == mcma_pkg::OP_WORKER)
        begin
            if (workers_held >= NPAIRS) dropped_seen = 1'b1;
            else
            begin
                worker_r[workers_held] = r;
                worker_c[workers_held] = c;
                workers_held++;
            end
        end
        else if (o == mcma_pkg::OP_SOLVE)
        begin
            res.mismatch = (houses_held != workers_held);
            t = res.mismatch ? 0 : best_total(int'(houses_held));
            if (t > int'(mcma_pkg::COST_SAT)) t = int'(mcma_pkg::COST_SAT);
            res.cost = t[CSW-1:0];
            res.ovf = dropped_seen;
            pending_totals.push_back(res);
            houses_held = 0;
            workers_held = 0;
            dropped_seen = 1'b0;
        end
    endtask

    // offer one request and hold it until accepted; valid stays high afterward
    task automatic send_req(logic [OPW-1:0] o, logic [FW-1:0] r,
                            logic [FW-1:0] c);
        in_valid <= 1'b1;
        op <= o;
        row <= r;
        col <= c;
        do
            @(posedge clk);
        while (in_stall);
        predict_request(o, r, c);
        if (o != OP_UNUSED) requests_sent++;
    endtask

    task automatic idle_gap(int n);
        if (n > 0)
        begin
            in_valid <= 1'b0;
            op <= OPW'($urandom);
            row <= FW'($urandom);
            col <= FW'($urandom);
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic maybe_gap();
        if ($urandom_range(0, 3) == 0) idle_gap(int'($urandom_range(1, 6)));
    endtask

    task automatic wait_drain();
        idle_gap(1);
        while (pending_totals.size() != 0) @(posedge clk);
    endtask

    function automatic logic [FW-1:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            default: return FW'($urandom);
        endcase
    endfunction

    task automatic load_set(int nh, int nw);
        int h;
        int w;
        h = 0;
        w = 0;
        while (h < nh || w < nw)
        begin
            if (w >= nw || (h < nh && $urandom_range(0, 1)))
            begin
                send_req(mcma_pkg::OP_HOUSE, rand_coord(), rand_coord());
                h++;
            end
            else
            begin
                send_req(mcma_pkg::OP_WORKER, rand_coord(), rand_coord());
                w++;
            end
            maybe_gap();
        end
    endtask

    task automatic test_directed();
        send_req(mcma_pkg::OP_SOLVE, '1, '1);              // empty stores
        send_req(mcma_pkg::OP_HOUSE, '0, '0);
        send_req(mcma_pkg::OP_WORKER, '1, '1);
        send_req(OP_UNUSED, 7'h55, 7'h2a);                 // ignored op code
        send_req(mcma_pkg::OP_SOLVE, '0, '0);
        // greedy nearest pairing is not optimal here
        send_req(mcma_pkg::OP_HOUSE, 7'd0, 7'd10);
        send_req(mcma_pkg::OP_HOUSE, 7'd0, 7'd20);
        send_req(mcma_pkg::OP_WORKER, 7'd0, 7'd15);
        send_req(mcma_pkg::OP_WORKER, 7'd0, 7'd26);
        send_req(mcma_pkg::OP_SOLVE, 7'h2a, 7'h55);
        // unequal counts
        send_req(mcma_pkg::OP_HOUSE, 7'd3, 7'd4);
        send_req(mcma_pkg::OP_HOUSE, 7'd5, 7'd6);
        send_req(mcma_pkg::OP_WORKER, 7'd7, 7'd8);
        send_req(mcma_pkg::OP_SOLVE, '0, '0);
        send_req(mcma_pkg::OP_WORKER, 7'd9, 7'd1);
        send_req(mcma_pkg::OP_SOLVE, '0, '0);
        wait_drain();
    endtask

    task automatic test_capacity();
        load_set(NPAIRS + 1, 5);                           // overflow and mismatch
        send_req(mcma_pkg::OP_SOLVE, '0, '0);
        wait_drain();
        load_set(NPAIRS, NPAIRS + 1);                      // full size solve, one dropped
        send_req(mcma_pkg::OP_SOLVE, '0, '0);
        wait_drain();
    endtask

    task automatic test_pressure();
        hold_off = 400;
        repeat (6)
        begin
            load_set(2, 2);
            send_req(mcma_pkg::OP_SOLVE, '0, '0);
        end
        wait_drain();
    endtask

    task automatic test_random();
        int n;
        int nh;
        int nw;
        while (requests_sent < ITEM_GOAL)
        begin
            n = ($urandom_range(0, 9) == 0) ? int'($urandom_range(7, 10))
                                             : int'($urandom_range(0, 6));
            nh = n;
            nw = n;
            if ($urandom_range(0, 7) == 0)
            begin
                if ($urandom_range(0, 1)) nh = n + int'($urandom_range(1, 2));
                else nw = n + int'($urandom_range(1, 2));
            end
            load_set(nh, nw);
            if ($urandom_range(0, 9) == 0)
                send_req(OP_UNUSED, FW'($urandom), FW'($urandom));
            send_req(mcma_pkg::OP_SOLVE, FW'($urandom), FW'($urandom));
            if ($urandom_range(0, 2) == 0) idle_gap(int'($urandom_range(1, 20)));
        end
        wait_drain();
    endtask

    // result side: stall pattern plus scoreboard check
    always @(posedge clk)
    begin
        solve_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_totals.size() == 0)
            begin
                $display("%0t: result with none expected, actual cost %0d mis %0b ovf %0b",
                         $time, total_cost, count_mismatch, overflowed);
                errors++;
            end
            else
            begin
                want = pending_totals.pop_front();
                solves_checked++;
                if (total_cost !== want.cost)
                begin
                    $display("%0t: total_cost expected %0d actual %0d",
                             $time, want.cost, total_cost);
                    errors++;
                end
                if (count_mismatch !== want.mismatch)
                begin
                    $display("%0t: count_mismatch expected %0b actual %0b",
                             $time, want.mismatch, count_mismatch);
                    errors++;
                end
                if (overflowed !== want.ovf)
                begin
                    $display("%0t: overflowed expected %0b actual %0b",
                             $time, want.ovf, overflowed);
                    errors++;
                end
            end
        end
        if (hold_off > 0)
        begin
            hold_off <= hold_off - 1;
            out_stall <= 1'b1;
        end
        else if ((cycles / 64) % 4 == 3)
            out_stall <= 1'b0;                             // stall-free stretch
        else
            out_stall <= ($urandom_range(0, 3) == 0);
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        op = mcma_pkg::OP_HOUSE;
        row = '0;
        col = '0;
        out_stall = 1'b0;
        hold_off = 0;
        cycles = 0;
        errors = 0;
        requests_sent = 0;
        solves_checked = 0;
        houses_held = 0;
        workers_held = 0;
        dropped_seen = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_capacity();
        test_pressure();
        test_random();
        repeat (50) @(posedge clk);
        $display("covered %0d load and solve requests, %0d solve results checked",
                 requests_sent, solves_checked);
        $display("including empty, unequal, overflow, full size and ignored op requests");
        if (errors == 0 && pending_totals.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
